### rtl/gdf_pkg.sv
package gdf_pkg;

  // ASCII codes used in the text stream
  localparam logic [6:0] CH_COMMA = 7'd44;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_ZERO  = 7'd48;

  // status from the converter to the emitter
  typedef struct packed {
    logic done;  // one-cycle pulse: BCD digits valid
    logic neg;   // sign of the converted value
  } conv_stat_t;

endpackage

### rtl/gdf_bcd_conv.sv
// Bit-serial binary to BCD (shift and add-3), one input bit per cycle.
module gdf_bcd_conv #(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  output gdf_pkg::conv_stat_t           stat_o,
  output logic [NUM_DIGITS*4-1:0]       digits_o
);
  import gdf_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                    busy_q, done_q;
  logic [CW-1:0]           cnt_q;
  logic [VALUE_WIDTH-1:0]  mag_q;
  logic [NUM_DIGITS*4-1:0] bcd_q, adj;
  logic                    neg_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                 : bcd_q[i*4 +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitude of the most negative value wraps to 2**(W-1), read unsigned
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
      neg_q <= value_i[VALUE_WIDTH-1];
      bcd_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_q <= {adj[NUM_DIGITS*4-2:0], mag_q[VALUE_WIDTH-1]};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.neg  = neg_q;
  assign digits_o    = bcd_q;

endmodule

### rtl/gdf_emit.sv
// Walks the BCD digits top down, drops leading zeros, inserts sign and
// commas, and feeds the output register at most one character per step.
module gdf_emit #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gdf_pkg::conv_stat_t     stat_i,
  input  logic [NUM_DIGITS*4-1:0] digits_i,
  input  logic                    style_i,
  output logic                    busy_o,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [6:0]              text_char_o,
  output logic                    last_char_o
);
  import gdf_pkg::*;

  localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [1:0] M3_INIT = 2'((NUM_DIGITS - 1) % 3);

  logic                    active_q, started_q, minus_q, comma_done_q, valid_q;
  logic [NUM_DIGITS*4-1:0] dig_q;
  logic [IW-1:0]           idx_q;
  logic [1:0]              m3_q;
  logic [6:0]              char_q;
  logic                    last_q;

  logic       out_free, step, is_last, comma_here;
  logic       do_minus, do_skip, do_comma, do_digit, advance;
  logic [3:0] top_dig;

  // comma goes between digit idx+1 and digit idx when idx+1 is a group edge
  always_comb begin
    top_dig    = dig_q[NUM_DIGITS*4-1 -: 4];
    is_last    = (idx_q == '0);
    comma_here = style_i ? (idx_q >= IW'(2) && !idx_q[0])
                         : (m3_q == 2'd2);
    out_free   = !valid_q || !stall_i;
    step       = active_q && out_free;
    do_minus   = step && minus_q;
    do_skip    = step && !minus_q && !started_q && top_dig == 4'd0 && !is_last;
    do_comma   = step && !minus_q && started_q && comma_here && !comma_done_q;
    do_digit   = step && !minus_q && !do_skip && !do_comma;
    advance    = do_skip || do_digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      started_q    <= 1'b0;
      minus_q      <= 1'b0;
      comma_done_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      if (stat_i.done) begin
        active_q     <= 1'b1;
        started_q    <= 1'b0;
        minus_q      <= stat_i.neg;
        comma_done_q <= 1'b0;
      end else begin
        if (do_minus) minus_q <= 1'b0;
        if (do_comma) comma_done_q <= 1'b1;
        if (do_digit) begin
          started_q    <= 1'b1;
          comma_done_q <= 1'b0;
          if (is_last) active_q <= 1'b0;
        end
      end
      if (do_minus || do_comma || do_digit) begin
        valid_q <= 1'b1;
      end else if (out_free) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_i.done) begin
      dig_q <= digits_i;
      idx_q <= IW'(NUM_DIGITS - 1);
      m3_q  <= M3_INIT;
    end else if (advance) begin
      dig_q <= {dig_q[NUM_DIGITS*4-5:0], 4'd0};
      idx_q <= idx_q - 1'b1;
      m3_q  <= (m3_q == 2'd0) ? 2'd2 : m3_q - 2'd1;
    end
    if (do_minus) begin
      char_q <= CH_MINUS;
      last_q <= 1'b0;
    end else if (do_comma) begin
      char_q <= CH_COMMA;
      last_q <= 1'b0;
    end else if (do_digit) begin
      char_q <= CH_ZERO + {3'b000, top_dig};
      last_q <= is_last;
    end
  end

  assign busy_o      = active_q;
  assign valid_o     = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

### rtl/grouped_decimal_formatter_core.sv
// Grouped decimal formatter.
// Input channel (valid_i / stall_o / value_i) takes one signed integer;
// output channel (valid_o / stall_i / text_char_o / last_char_o) returns
// its decimal text in ASCII, most significant first: optional '-', digits,
// and ',' separators. last_char_o marks the final character of a number.
// cfg_we_i / cfg_wdata_i write the grouping style: 0 = thousands,
// 1 = Indian (lowest three digits, then pairs). Write only while idle.
// One number at a time: stall_o is low only in idle. After a transfer the
// bit-serial BCD converter takes in one input bit per cycle; then the emitter
// steps through the BCD digit slots, a skipped leading zero, a sign or a
// comma each taking a step of its own.
// When the receiver stalls, the output register holds its character and
// the emitter waits; the last character may still sit in the output
// register while the next number is taken in and converted.
// Reset clears the control state and sets the style to thousands; no
// character is pending afterwards.
module grouped_decimal_formatter_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [6:0]                    text_char_o,
  output logic                          last_char_o
);
  import gdf_pkg::*;

  // decimal digits enough for 2**(W-1): floor(W*log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic                    style_q;
  logic                    accept, emit_busy;
  conv_stat_t              conv_stat;
  logic [NUM_DIGITS*4-1:0] digits;

  assign stall_o = (state_q != ST_IDLE);
  assign accept  = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= 1'b0;
    end else if (cfg_we_i) begin
      style_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  gdf_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .value_i  (value_i),
    .stat_o   (conv_stat),
    .digits_o (digits)
  );

  gdf_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (conv_stat),
    .digits_i    (digits),
    .style_i     (style_q),
    .busy_o      (emit_busy),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  // a transfer in always starts a conversion
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CONV)
    else $error("input transfer did not start conversion");

  // while converting, only the previous number's final character may wait
  a_conv_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && valid_o) |-> last_char_o)
    else $error("non-final character pending during conversion");

  // every character is a sign, a comma or a decimal digit
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (text_char_o == CH_COMMA || text_char_o == CH_MINUS ||
                 (text_char_o >= CH_ZERO && text_char_o <= CH_ZERO + 7'd9)))
    else $error("illegal character code");

  // the final character never is a sign or a comma
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_char_o) |-> (text_char_o >= CH_ZERO))
    else $error("final character is not a digit");

endmodule

### sim/grouped_decimal_formatter_checker.sv
module grouped_decimal_formatter_checker #(
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  logic [VW-1:0] value_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  logic [6:0]    text_char_i,
  input  logic          last_char_i,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_beat_t;

  text_beat_t expected_text[$];
  logic       indian_style;
  int         mismatches;

  // Decimal text of one value, most significant character first.
  function automatic void predict_text(input logic [VW-1:0] raw, input logic indian);
    logic          neg;
    logic [VW-1:0] mag;
    logic [3:0]    digs[64];
    logic [6:0]    rev[96];
    int            nd;
    int            n;
    int            d;
    text_beat_t    beat;
    neg = raw[VW-1];
    // unsigned negate: the most negative value comes out as its true magnitude
    mag = neg ? (~raw + 1'b1) : raw;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0);
    n = 0;
    for (d = 0; d < nd; d++) begin
      if (d > 0 && (indian ? (d >= 3 && (d - 3) % 2 == 0) : (d % 3 == 0))) begin
        rev[n] = gdf_pkg::CH_COMMA;
        n++;
      end
      rev[n] = gdf_pkg::CH_ZERO + digs[d];
      n++;
    end
    if (neg) begin
      rev[n] = gdf_pkg::CH_MINUS;
      n++;
    end
    for (d = 0; d < n; d++) begin
      beat.ch   = rev[n - 1 - d];
      beat.last = (d == n - 1);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      indian_style = 1'b0;
      mismatches   = 0;
      expected_text.delete();
    end else begin
      if (cfg_we_i) begin
        indian_style = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_text(value_i, indian_style);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected char: text_char %0d last_char %0d", text_char_i, last_char_i);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (text_char_i !== want.ch) begin
            $error("text_char expected %0d got %0d", want.ch, text_char_i);
            mismatches++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char expected %0d got %0d", want.last, last_char_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_text.size();
  end

endmodule

### sim/grouped_decimal_formatter_core_tb.sv
module grouped_decimal_formatter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  // generous for ~450 numbers, even with heavy stalls
  localparam int CYCLE_LIMIT = 400000;
  // grouping style codes for the config register
  localparam logic STYLE_THOUSANDS = 1'b0;
  localparam logic STYLE_INDIAN    = 1'b1;
  localparam int PHASES     = 8;
  localparam int PHASE_NUMS = 52;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic          cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  logic [VW-1:0] value;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [6:0]    text_char;
  logic          last_char;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct;   // chance per cycle that the sender holds off
  int recv_stall_pct;  // chance per cycle that the receiver stalls

  // Directed numbers: zero, digit-count boundaries, both extremes, and
  // values that put commas in every position for either style.
  logic [VW-1:0] directed_nums[12] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd999, 32'd1000, -32'sd1000,
    32'd100000, 32'd1000000, 32'd123456789, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001
  };

  grouped_decimal_formatter_core #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .valid_i    (in_valid),
    .stall_o    (in_stall),
    .value_i    (value),
    .valid_o    (out_valid),
    .stall_i    (out_stall),
    .text_char_o(text_char),
    .last_char_o(last_char)
  );

  grouped_decimal_formatter_checker #(
    .VW(VW)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .value_i     (value),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .text_char_i (text_char),
    .last_char_i (last_char),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver side: random stall at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung block or a lost character ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One number onto the input channel. Random hold-off cycles first (value
  // wiggles meanwhile), then valid and payload stay put until the transfer.
  // Returns in the time step of the transfer edge.
  task automatic send_number(input logic [VW-1:0] num);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender goes quiet until every predicted character has come out.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic drain_text;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Only called with the block idle (after reset or after a drain).
  task automatic write_style(input logic style);
    cfg_we    <= 1'b1;
    cfg_wdata <= style;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [VW-1:0] pow10[10];
    logic [VW-1:0] num;
    int            p;
    int            i;
    int            k;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    value          = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pow10[0] = 1;
    for (k = 1; k < 10; k++) pow10[k] = pow10[k-1] * 10;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset style (thousands) first, then the same set in Indian style.
    foreach (directed_nums[i]) send_number(directed_nums[i]);
    drain_text();
    write_style(STYLE_INDIAN);
    foreach (directed_nums[i]) send_number(directed_nums[i]);
    drain_text();

    // Random phases. Idle mode cycles through none / sender / receiver / both,
    // and the style pattern makes every mode run under both styles.
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      write_style(((p + p / 4) % 2) ? STYLE_INDIAN : STYLE_THOUSANDS);
      for (i = 0; i < PHASE_NUMS; i++) begin
        case ($urandom_range(5))
          0, 1: num = $urandom;                            // full range, all bits
          2: num = $urandom_range(0, pow10[$urandom_range(1, 9)]);
          3: begin                                         // around a power of ten
            num = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
            if ($urandom_range(1)) num = -num;
          end
          4: begin                                         // short negatives
            num = $urandom_range(0, pow10[$urandom_range(1, 6)]);
            num = -num;
          end
          default: begin                                   // extremes
            case ($urandom_range(3))
              0: num = 32'h8000_0000;
              1: num = 32'h7FFF_FFFF;
              2: num = 32'h8000_0001;
              default: num = '0;
            endcase
          end
        endcase
        send_number(num);
        // occasional full pause mid-phase
        if ($urandom_range(39) == 0) drain_text();
      end
      drain_text();
    end

    // Tail: catch any stray characters after the last expected one.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (VW + 40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
